>>> rtl/core/cta_pkg.sv
package cta_pkg;

  // milliseconds to whole seconds by reciprocal multiply:
  // floor(n/1000) = (n * MsRecip) >> RecipSh for every 32-bit n
  localparam int unsigned MsPerSec = 1000;
  localparam int unsigned RecipW   = 29;
  localparam int unsigned RecipSh  = 38;
  localparam logic [RecipW-1:0] MsRecip = 29'd274877907;
  localparam int unsigned SecW     = 23;   // (2^32-1)/1000 fits in 23 bits
  localparam int unsigned MulAW    = 25;
  localparam int unsigned MulBW    = 18;
  localparam int unsigned ProdW    = MulAW + MulBW;

  // adjust codes
  localparam logic [1:0] ADJ_NONE = 2'b00;
  localparam logic [1:0] ADJ_INC  = 2'b01;
  localparam logic [1:0] ADJ_DEC  = 2'b11;

  typedef enum logic [1:0] {
    REG_PERIOD,
    REG_LOW,
    REG_HIGH
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DIFF,
    ST_ZERO,
    ST_FLAT,
    ST_NUM,
    ST_LOW,
    ST_HIGH,
    ST_EMIT
  } step_e;

  typedef enum logic [3:0] {
    OP_LATCH,
    OP_CHECK,
    OP_DIV,
    OP_DIFF,
    OP_MUL_FLAT,
    OP_FLAT,
    OP_NUM,
    OP_LOW,
    OP_HIGH,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_ACCEPT,
    C_SOON,
    C_FIRST,
    C_DSEC_ZERO,
    C_FLAT,
    C_BELOW,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e jmp;
    step_e nxt;
  } ctrl_t;

  typedef struct packed {
    logic no_accept;
    logic soon;
    logic first;
    logic dsec_zero;
    logic flat;
    logic below;
    logic out_busy;
  } stat_t;

  // microcode: taken condition jumps to jmp, otherwise falls to nxt
  function automatic ctrl_t rom(step_e s);
    ctrl_t w;
    unique case (s)
      ST_IDLE:  w = '{op: OP_LATCH,    cond: C_NO_ACCEPT, jmp: ST_IDLE, nxt: ST_CHECK};
      ST_CHECK: w = '{op: OP_CHECK,    cond: C_SOON,      jmp: ST_EMIT, nxt: ST_DIV};
      ST_DIV:   w = '{op: OP_DIV,      cond: C_NEVER,     jmp: ST_DIFF, nxt: ST_DIFF};
      ST_DIFF:  w = '{op: OP_DIFF,     cond: C_FIRST,     jmp: ST_EMIT, nxt: ST_ZERO};
      ST_ZERO:  w = '{op: OP_MUL_FLAT, cond: C_DSEC_ZERO, jmp: ST_EMIT, nxt: ST_FLAT};
      ST_FLAT:  w = '{op: OP_FLAT,     cond: C_FLAT,      jmp: ST_EMIT, nxt: ST_NUM};
      ST_NUM:   w = '{op: OP_NUM,      cond: C_NEVER,     jmp: ST_EMIT, nxt: ST_LOW};
      ST_LOW:   w = '{op: OP_LOW,      cond: C_BELOW,     jmp: ST_EMIT, nxt: ST_HIGH};
      ST_HIGH:  w = '{op: OP_HIGH,     cond: C_NEVER,     jmp: ST_EMIT, nxt: ST_EMIT};
      ST_EMIT:  w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  jmp: ST_EMIT, nxt: ST_IDLE};
      default:  w = '{op: OP_LATCH,    cond: C_NEVER,     jmp: ST_IDLE, nxt: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/cta_seq.sv
module cta_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cta_pkg::stat_t  stat_i,
  output cta_pkg::ctrl_t  ctrl_o
);

  cta_pkg::step_e pc_q, pc_d;
  cta_pkg::ctrl_t word;
  logic           taken;

  assign word   = cta_pkg::rom(pc_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.cond)
      cta_pkg::C_NEVER:     taken = 1'b0;
      cta_pkg::C_NO_ACCEPT: taken = stat_i.no_accept;
      cta_pkg::C_SOON:      taken = stat_i.soon;
      cta_pkg::C_FIRST:     taken = stat_i.first;
      cta_pkg::C_DSEC_ZERO: taken = stat_i.dsec_zero;
      cta_pkg::C_FLAT:      taken = stat_i.flat;
      cta_pkg::C_BELOW:     taken = stat_i.below;
      cta_pkg::C_OUT_BUSY:  taken = stat_i.out_busy;
      default:              taken = 1'b0;
    endcase
    pc_d = taken ? word.jmp : word.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cta_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> rtl/core/cooling_trend_adjuster.sv
// channel | dir | handshake                       | payload
// s_axis  | in  | s_axis_tvalid_i/s_axis_tready_o | now_ms, temperature, setpoint
// m_axis  | out | m_axis_tvalid_o/m_axis_tready_i | adjust, evaluated
// cfg     | in  | cfg_we_i (no wait)              | cfg_idx_i, cfg_data_i
//
// one transaction in flight; no new input is taken until the microcode program
// is through with the last one: one reciprocal-multiply step that turns now_ms
// into whole seconds plus the compare steps (a too-early sample skips straight
// to the result)
// the finished result sits in an output register, so the next input is taken
// while it still waits; the program holds in its last step while that register
// is full and not being drained
// rst_ni clears config to 1000/30/120 ms/s/s and the stored sample to zero
module cooling_trend_adjuster (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // now_ms[31:0], temperature[47:32], setpoint[63:48]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // adjust[1:0], evaluated[2], zero[7:3]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned SecW    = cta_pkg::SecW;
  localparam int unsigned RecipW  = cta_pkg::RecipW;
  localparam int unsigned RecipSh = cta_pkg::RecipSh;
  localparam int unsigned ProdW   = cta_pkg::ProdW;
  localparam int unsigned MulAW   = cta_pkg::MulAW;
  localparam int unsigned MulBW   = cta_pkg::MulBW;

  // sequencer
  cta_pkg::ctrl_t ctrl;
  cta_pkg::stat_t stat;

  cta_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // config registers
  logic [15:0] period_q, low_q, high_q;

  // stored sample
  logic [31:0]        prev_time_q;
  logic signed [15:0] prev_temp_q;
  logic [SecW-1:0]    prev_sec_q;

  // latched input
  logic [31:0]        now_q;
  logic signed [15:0] temp_q, setp_q;

  // whole seconds of the latched time
  logic [31+RecipW:0] recip_p;
  logic [SecW-1:0]    quot_q;

  // working values
  logic signed [23:0]      dsec_q;
  logic signed [16:0]      dtemp_q, diff_q;
  logic signed [ProdW-1:0] mul_q, num_q;
  logic [1:0]              adj_q;
  logic                    ev_q;

  // output register
  logic       out_valid_q;
  logic [1:0] out_adj_q;
  logic       out_ev_q;

  logic accept;
  assign s_axis_tready_o = (ctrl.op == cta_pkg::OP_LATCH);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // too-early check on the wrapping millisecond counter
  logic [31:0] elapsed;
  assign elapsed = now_q - prev_time_q;

  // divide by 1000 as a multiply by the scaled reciprocal, exact for 32-bit input
  assign recip_p = now_q * cta_pkg::MsRecip;

  // differences against the stored sample
  logic signed [23:0] dsec_c;
  logic signed [16:0] dtemp_c, diff_c;
  assign dsec_c  = $signed({1'b0, quot_q}) - $signed({1'b0, prev_sec_q});
  assign dtemp_c = $signed({temp_q[15], temp_q}) - $signed({prev_temp_q[15], prev_temp_q});
  assign diff_c  = $signed({setp_q[15], setp_q}) - $signed({temp_q[15], temp_q});

  // magnitudes for the flat-trend test
  logic [16:0]     adt;
  logic [23:0]     ads_full;
  logic [SecW-1:0] ads;
  assign adt      = dtemp_q[16] ? 17'(-dtemp_q) : 17'(dtemp_q);
  assign ads_full = dsec_q[23] ? 24'(-dsec_q) : 24'(dsec_q);
  assign ads      = ads_full[SecW-1:0];

  // shared multiplier, operands picked by the control word
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  always_comb begin
    unique case (ctrl.op)
      cta_pkg::OP_MUL_FLAT: begin
        mul_a = MulAW'(cta_pkg::MsPerSec);
        mul_b = {1'b0, adt};
      end
      cta_pkg::OP_FLAT: begin
        mul_a = {dsec_q[23], dsec_q};
        mul_b = {diff_q[16], diff_q};
      end
      cta_pkg::OP_NUM: begin
        mul_a = {9'b0, low_q};
        mul_b = {dtemp_q[16], dtemp_q};
      end
      cta_pkg::OP_LOW: begin
        mul_a = {9'b0, high_q};
        mul_b = {dtemp_q[16], dtemp_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // decisions; dtemp is nonzero past the flat test
  logic       flat, dtemp_pos, below, above;
  logic [1:0] toward;
  assign flat      = mul_q < $signed({16'b0, ads, 4'b0});
  assign dtemp_pos = !dtemp_q[16];
  assign below     = dtemp_pos ? (num_q < mul_q) : (num_q > mul_q);
  assign above     = dtemp_pos ? (num_q > mul_q) : (num_q < mul_q);
  assign toward    = (diff_q > 0) ? cta_pkg::ADJ_DEC :
                     (diff_q < 0) ? cta_pkg::ADJ_INC : cta_pkg::ADJ_NONE;

  logic out_busy;
  assign out_busy = out_valid_q && !m_axis_tready_i;

  always_comb begin
    stat.no_accept = !accept;
    stat.soon      = elapsed < {16'b0, period_q};
    stat.first     = (prev_time_q == '0);
    stat.dsec_zero = (dsec_q == '0);
    stat.flat      = flat;
    stat.below     = below;
    stat.out_busy  = out_busy;
  end

  // control state, config and stored sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= 16'd1000;
      low_q       <= 16'd30;
      high_q      <= 16'd120;
      prev_time_q <= '0;
      prev_temp_q <= '0;
      prev_sec_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cta_pkg::REG_PERIOD) period_q <= cfg_data_i;
        if (cfg_idx_i == cta_pkg::REG_LOW)    low_q    <= cfg_data_i;
        if (cfg_idx_i == cta_pkg::REG_HIGH)   high_q   <= cfg_data_i;
      end
      if (ctrl.op == cta_pkg::OP_DIFF) begin
        prev_time_q <= now_q;
        prev_temp_q <= temp_q;
        prev_sec_q  <= quot_q;
      end
      if (ctrl.op == cta_pkg::OP_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    unique case (ctrl.op)
      cta_pkg::OP_LATCH: begin
        if (accept) begin
          now_q  <= s_axis_tdata_i[31:0];
          temp_q <= s_axis_tdata_i[47:32];
          setp_q <= s_axis_tdata_i[63:48];
        end
      end
      cta_pkg::OP_CHECK: begin
        ev_q  <= !stat.soon;
        adj_q <= cta_pkg::ADJ_NONE;
      end
      cta_pkg::OP_DIV: begin
        quot_q <= recip_p[RecipSh +: SecW];
      end
      cta_pkg::OP_DIFF: begin
        dsec_q  <= dsec_c;
        dtemp_q <= dtemp_c;
        diff_q  <= diff_c;
      end
      cta_pkg::OP_MUL_FLAT: begin
        mul_q <= mul_p;
      end
      cta_pkg::OP_FLAT: begin
        if (flat) adj_q <= toward;
        mul_q <= mul_p;
      end
      cta_pkg::OP_NUM: begin
        num_q <= mul_q;
        mul_q <= mul_p;
      end
      cta_pkg::OP_LOW: begin
        if (below) adj_q <= toward;
        mul_q <= mul_p;
      end
      cta_pkg::OP_HIGH: begin
        if (above) adj_q <= 2'(-toward);
      end
      cta_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_adj_q <= adj_q;
          out_ev_q  <= ev_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_ev_q, out_adj_q};

  // an accepted transaction starts the program, so input is closed next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input still open after accept");

  // a stalled result keeps its payload until it is taken
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");

  // a sample that was not evaluated never proposes a change
  a_idle_no_adjust: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ev_q) |-> (out_adj_q == cta_pkg::ADJ_NONE))
    else $error("adjust on a skipped sample");

  // leaving the last step always loads the output register
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == cta_pkg::OP_EMIT && !out_busy) |=> m_axis_tvalid_o)
    else $error("result lost at emit");

endmodule

>>> sim/cooling_trend_adjuster_test.sv
module cooling_trend_adjuster_test;

  // one result transaction: adjust code and the evaluated flag
  typedef struct packed {
    logic [1:0] adjust;
    logic       evaluated;
  } verdict_t;

  // directed plan: a sample transaction or a register write
  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_e;

  typedef struct {
    row_e               kind;
    cta_pkg::reg_e      idx;
    logic [15:0]        val;
    logic [31:0]        now;
    logic signed [15:0] temp;
    logic signed [15:0] sp;
    bit                 typed;
    verdict_t           want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // now_ms[31:0], temperature[47:32], setpoint[63:48]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // adjust[1:0], evaluated[2], zero[7:3]
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  cooling_trend_adjuster u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor copy of the registers and of the held sample
  logic [15:0]        cfg_period_ms;
  logic [15:0]        cfg_low_s;
  logic [15:0]        cfg_high_s;
  logic [31:0]        held_time_ms;
  logic signed [15:0] held_temp;

  verdict_t pending_verdicts[$];
  row_t     plan[$];
  int       err_cnt;
  int       send_idle_pct;
  int       recv_idle_pct;

  // random walk of the generated samples
  logic [31:0] walk_now;
  int          walk_temp;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // generous cap on the simulation time
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // trend decision for one sample; advances the held sample when evaluated
  function automatic verdict_t predict_trend(logic [31:0] now, logic signed [15:0] temp,
                                             logic signed [15:0] sp);
    verdict_t    v;
    logic [31:0] elapsed;
    longint      dsec, dtemp, diff, adt, ads, num, lo, hi;
    logic [1:0]  toward, away;
    logic        below, above;
    v.adjust    = cta_pkg::ADJ_NONE;
    v.evaluated = 1'b0;
    elapsed     = now - held_time_ms;
    if (elapsed >= {16'b0, cfg_period_ms}) begin
      v.evaluated = 1'b1;
      if (held_time_ms == 32'd0) begin
        // nothing held yet: just take the sample
        held_time_ms = now;
        held_temp    = temp;
      end else begin
        // second counts, signed difference (negative after a counter wrap)
        dsec  = longint'(now / 32'd1000) - longint'(held_time_ms / 32'd1000);
        dtemp = longint'(temp) - longint'(held_temp);
        diff  = longint'(sp) - longint'(temp);
        held_time_ms = now;
        held_temp    = temp;
        toward = (diff > 0) ? cta_pkg::ADJ_DEC :
                 (diff < 0) ? cta_pkg::ADJ_INC : cta_pkg::ADJ_NONE;
        away   = (diff > 0) ? cta_pkg::ADJ_INC :
                 (diff < 0) ? cta_pkg::ADJ_DEC : cta_pkg::ADJ_NONE;
        if (dsec != 0) begin
          adt = (dtemp < 0) ? -dtemp : dtemp;
          ads = (dsec < 0) ? -dsec : dsec;
          if (1000 * adt < 16 * ads) begin
            v.adjust = toward;
          end else begin
            // time-to-target diff*dsec/dtemp against the bounds, no division
            num   = diff * dsec;
            lo    = longint'(cfg_low_s) * dtemp;
            hi    = longint'(cfg_high_s) * dtemp;
            below = (dtemp > 0) ? (num < lo) : (num > lo);
            above = (dtemp > 0) ? (num > hi) : (num < hi);
            if (below) v.adjust = toward;
            else if (above) v.adjust = away;
          end
        end
      end
    end
    return v;
  endfunction

  function automatic row_t sample_row(logic [31:0] now, logic signed [15:0] temp,
                                      logic signed [15:0] sp);
    row_t r;
    r.kind  = ROW_SAMPLE;
    r.idx   = cta_pkg::REG_PERIOD;
    r.val   = '0;
    r.now   = now;
    r.temp  = temp;
    r.sp    = sp;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [31:0] now, logic signed [15:0] temp,
                                     logic signed [15:0] sp, verdict_t want);
    row_t r;
    r       = sample_row(now, temp, sp);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t write_row(cta_pkg::reg_e idx, logic [15:0] val);
    row_t r;
    r      = sample_row('0, '0, '0);
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // offer one sample, honoring sender idling; returns at the accepting edge
  task automatic send_sample(logic [31:0] now, logic signed [15:0] temp,
                             logic signed [15:0] sp, bit typed, verdict_t want);
    verdict_t v;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {sp, temp, now};
    do @(posedge clk_i); while (!s_axis_tready_o);
    v = predict_trend(now, temp, sp);
    if (typed) v = want;
    pending_verdicts.push_back(v);
  endtask

  // register write, only once every result has drained
  task automatic write_reg(cta_pkg::reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    unique case (idx)
      cta_pkg::REG_PERIOD: cfg_period_ms = val;
      cta_pkg::REG_LOW:    cfg_low_s     = val;
      cta_pkg::REG_HIGH:   cfg_high_s    = val;
      default:             ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random sample, mostly a plausible slow trend with some noise and jumps
  task automatic next_random(output logic [31:0] now, output logic signed [15:0] temp,
                             output logic signed [15:0] sp);
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 3) now = $urandom();
    else if (r < 5) now = 32'd0;
    else if (r < 25) now = walk_now + $urandom_range(0, cfg_period_ms);
    else if (r < 60) now = walk_now + cfg_period_ms + $urandom_range(0, 3000);
    else now = walk_now + cfg_period_ms + $urandom_range(1000, 200000);
    walk_now = now;

    if ($urandom_range(0, 99) < 8) begin
      t = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      t = walk_temp + int'($urandom_range(0, 60)) - 30;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
    end
    walk_temp = t;
    temp = t[15:0];

    if ($urandom_range(0, 99) < 8) begin
      sp = 16'($urandom_range(0, 65535));
    end else begin
      t  = walk_temp + int'($urandom_range(0, 4000)) - 2000;
      sp = t[15:0];
    end
  endtask

  // receiver: random stall at the falling edge
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected result: expected none, actual adjust %b evaluated %b",
                 $time, m_axis_tdata_o[1:0], m_axis_tdata_o[2]);
        err_cnt++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (m_axis_tdata_o[1:0] !== exp_v.adjust) begin
          $display("%0t adjust mismatch: expected %b, actual %b",
                   $time, exp_v.adjust, m_axis_tdata_o[1:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[2] !== exp_v.evaluated) begin
          $display("%0t evaluated mismatch: expected %b, actual %b",
                   $time, exp_v.evaluated, m_axis_tdata_o[2]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [31:0]        now;
    logic signed [15:0] temp;
    logic signed [15:0] sp;
    logic [15:0]        phase_cfg[6][3];
    row_t               row;

    // all inputs known from time zero
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    err_cnt         = 0;
    send_idle_pct   = 9;
    recv_idle_pct   = 76;
    cfg_period_ms   = 16'd1000;
    cfg_low_s       = 16'd30;
    cfg_high_s      = 16'd120;
    held_time_ms    = '0;
    held_temp       = '0;
    walk_now        = 32'd100000;
    walk_temp       = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed plan, reset settings 1000 ms / 30 s / 120 s
    plan.push_back(typed_row(32'd500, 0, 0,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b0}));     // too soon
    plan.push_back(typed_row(32'd2000, 100, 200,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b1}));     // first sample
    plan.push_back(typed_row(32'd2500, 100, 200,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b0}));
    // flat trend, all three target directions
    plan.push_back(typed_row(32'd3000, 100, 300,
                             verdict_t'{cta_pkg::ADJ_DEC, 1'b1}));
    plan.push_back(typed_row(32'd4000, 100, -32768,
                             verdict_t'{cta_pkg::ADJ_INC, 1'b1}));
    plan.push_back(typed_row(32'd5000, 100, 100,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b1}));
    plan.push_back(sample_row(32'd6000, 200, 300));          // fast
    plan.push_back(sample_row(32'd7000, 201, 32767));        // slow
    plan.push_back(sample_row(32'd8000, 202, 252));          // in range
    plan.push_back(sample_row(32'd9000, -32768, 32767));     // temperature extremes
    plan.push_back(sample_row(32'd12000, 32767, -32768));
    plan.push_back(sample_row(32'd15000, 32760, 32767));     // falling slowly
    plan.push_back(write_row(cta_pkg::REG_PERIOD, 16'd0));
    // same second count: zero-second gap
    plan.push_back(typed_row(32'd15999, 32760, 0,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b1}));
    plan.push_back(typed_row(32'd15999, 0, 32760,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b1}));
    plan.push_back(sample_row(32'hFFFF_FFFF, 0, 0));         // top of the counter
    plan.push_back(sample_row(32'h0000_1000, 16, -16));      // wrapped, negative gap
    plan.push_back(sample_row(32'd0, 5, 5));                 // stores a zero time
    plan.push_back(typed_row(32'd2000, 5, 5,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b1}));     // first again
    plan.push_back(write_row(cta_pkg::REG_LOW, 16'd0));
    plan.push_back(write_row(cta_pkg::REG_HIGH, 16'd65535));
    plan.push_back(sample_row(32'd5000, 40, 1000));
    plan.push_back(write_row(cta_pkg::REG_PERIOD, 16'd65535));
    plan.push_back(write_row(cta_pkg::REG_LOW, 16'd65535));
    plan.push_back(write_row(cta_pkg::REG_HIGH, 16'd0));
    plan.push_back(sample_row(32'd70000, 60, 0));
    plan.push_back(typed_row(32'd70100, 60, 0,
                             verdict_t'{cta_pkg::ADJ_NONE, 1'b0}));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.val);
      else send_sample(row.now, row.temp, row.sp, row.typed, row.want);
    end

    // random phases: settings per phase, idling pattern changes every two phases
    phase_cfg[0] = '{16'd1000, 16'd30, 16'd120};
    phase_cfg[1] = '{16'd0, 16'd0, 16'd65535};
    phase_cfg[2] = '{16'd65535, 16'd65535, 16'd0};
    phase_cfg[3] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535))};
    phase_cfg[4] = '{16'd200, 16'd5, 16'd40};
    phase_cfg[5] = '{16'd1, 16'd100, 16'd200};

    for (int p = 0; p < 6; p++) begin
      write_reg(cta_pkg::REG_PERIOD, phase_cfg[p][0]);
      write_reg(cta_pkg::REG_LOW, phase_cfg[p][1]);
      write_reg(cta_pkg::REG_HIGH, phase_cfg[p][2]);
      if (p < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 76;
      end else if (p < 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 240; n++) begin
        next_random(now, temp, sp);
        send_sample(now, temp, sp, 1'b0, '0);
      end
    end

    // drain, then a short quiet tail to catch stray results
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (err_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cta_pkg.sv
rtl/core/cta_seq.sv
rtl/core/cooling_trend_adjuster.sv
sim/cooling_trend_adjuster_test.sv
